// ===== hdl/hbs_pkg.sv =====
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared constants, register codes and types of the height-field sampler.
// ----------------------------------------------------------------------------
package hbs_pkg;

    localparam int STORE_DEPTH_DEF   = 65536;
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int COUNT_BITS    = 13;
    localparam int FACE_BITS     = 16;
    localparam int POS_BITS      = 31;
    localparam int WORLD_BITS    = 32;
    localparam int ADDR_BITS     = 16;
    localparam int VALUE_BITS    = 16;
    localparam int HEIGHT_BITS   = 24;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int INDEX_BITS    = 27;
    localparam int DIV_STEP      = 4;

    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_WIDTH = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_DEPTH = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPACING    = 2'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                  op;
        logic                  unset;
        logic [ADDR_BITS-1:0]  addr;
        logic [VALUE_BITS-1:0] value;
    } side_t;

    // divider stages needed for a quotient of COUNT_BITS + fb bits
    function automatic int div_stages(input int fb);
        return (COUNT_BITS + fb + DIV_STEP - 1) / DIV_STEP;
    endfunction

endpackage

// ===== hdl/hbs_divider.sv =====
// ----------------------------------------------------------------------------
// hbs_divider
// Pipelined restoring divider: position scaled to grid units over face size,
// 4 quotient bits per stage, with an overflow flag for huge quotients.
// ----------------------------------------------------------------------------
module hbs_divider #(
    parameter int FRACTION_BITS = hbs_pkg::FRACTION_BITS_DEF
) (
    input  logic                                            clk,
    input  logic [hbs_pkg::div_stages(FRACTION_BITS)-1:0]   en,
    input  logic [hbs_pkg::POS_BITS-1:0]                    pos,
    input  logic [hbs_pkg::FACE_BITS-1:0]                   spacing,
    output logic [hbs_pkg::div_stages(FRACTION_BITS)*hbs_pkg::DIV_STEP-1:0] quo,
    output logic                                            ovf
);

    localparam int D   = hbs_pkg::div_stages(FRACTION_BITS);
    localparam int QP  = D * hbs_pkg::DIV_STEP;
    localparam int SHL = (FRACTION_BITS >= 8) ? FRACTION_BITS - 8 : 0;
    localparam int SHR = (FRACTION_BITS >= 8) ? 0 : 8 - FRACTION_BITS;
    localparam int NW  = hbs_pkg::POS_BITS + SHL;
    localparam int FW  = hbs_pkg::FACE_BITS;

    logic [FW-1:0] rem_reg [D];
    logic [QP-1:0] num_reg [D];
    logic          ovf_reg [D];
    logic [FW-1:0] rem_next [D];
    logic [QP-1:0] num_next [D];
    logic          ovf_next [D];
    logic [NW-1:0] num0;
    logic [FW-1:0] rem0;

    always_comb
    begin
        num0 = (NW'(pos) << SHL) >> SHR;
        rem0 = FW'(num0[NW-1:QP]);
    end

    always_comb
    begin
        logic [FW-1:0] r;
        logic [QP-1:0] n;
        logic [FW:0]   t;
        logic          q;
        for (int j = 0; j < D; j++)
        begin
            if (j == 0)
            begin
                r           = rem0;
                n           = num0[QP-1:0];
                ovf_next[j] = (rem0 >= spacing);
            end
            else
            begin
                r           = rem_reg[j-1];
                n           = num_reg[j-1];
                ovf_next[j] = ovf_reg[j-1];
            end
            for (int b = 0; b < hbs_pkg::DIV_STEP; b++)
            begin
                t = {r, n[QP-1]};
                if (t >= {1'b0, spacing})
                begin
                    r = FW'(t - {1'b0, spacing});
                    q = 1'b1;
                end
                else
                begin
                    r = t[FW-1:0];
                    q = 1'b0;
                end
                n = {n[QP-2:0], q};
            end
            rem_next[j] = r;
            num_next[j] = n;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < D; j++)
        begin
            if (en[j])
            begin
                rem_reg[j] <= rem_next[j];
                num_reg[j] <= num_next[j];
                ovf_reg[j] <= ovf_next[j];
            end
        end
    end

    assign quo = num_reg[D-1];
    assign ovf = ovf_reg[D-1];

endmodule

// ===== hdl/hbs_store.sv =====
// ----------------------------------------------------------------------------
// hbs_store
// Sample memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module hbs_store #(
    parameter int DEPTH       = hbs_pkg::STORE_DEPTH_DEF,
    parameter int SAMPLE_BITS = hbs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [SAMPLE_BITS-1:0]   wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [SAMPLE_BITS-1:0]   rdata_a,
    output logic [SAMPLE_BITS-1:0]   rdata_b
);

    logic [SAMPLE_BITS-1:0] mem [DEPTH];
    logic [SAMPLE_BITS-1:0] rdata_a_reg;
    logic [SAMPLE_BITS-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== hdl/hbs_blend.sv =====
// ----------------------------------------------------------------------------
// hbs_blend
// Bilinear blend of four samples in five register stages, with rounding to
// 8 fraction bits and saturation to the height range.
// ----------------------------------------------------------------------------
module hbs_blend #(
    parameter int SAMPLE_BITS   = hbs_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = hbs_pkg::FRACTION_BITS_DEF
) (
    input  logic                            clk,
    input  logic [4:0]                      en,
    input  logic [SAMPLE_BITS-1:0]          rd00,
    input  logic [SAMPLE_BITS-1:0]          rd10,
    input  logic [SAMPLE_BITS-1:0]          rd01,
    input  logic [SAMPLE_BITS-1:0]          rd11,
    input  logic [3:0]                      oor,
    input  logic [FRACTION_BITS-1:0]        fx,
    input  logic [FRACTION_BITS-1:0]        fz,
    input  logic                            unset,
    output logic [hbs_pkg::HEIGHT_BITS-1:0] height
);

    localparam int SB   = SAMPLE_BITS;
    localparam int FB   = FRACTION_BITS;
    localparam int WW   = FB + 1;
    localparam int PW   = SB + WW + 1;
    localparam int AW   = PW + 1;
    localparam int AHW  = AW - FB;
    localparam int QHW  = AHW + WW + 1;
    localparam int HW   = QHW + 1;
    localparam int LW   = FB + WW;
    localparam int LSW  = LW + 1;
    localparam int SW0  = HW + FB + 1;
    localparam int SW   = (SW0 > 25) ? SW0 : 25;
    localparam int SR   = 2 * FB - 8;
    localparam int HS   = (SR > 0) ? SR - 1 : 0;
    localparam int OW   = hbs_pkg::HEIGHT_BITS;

    localparam logic [WW-1:0]        ONE  = WW'(1) << FB;
    localparam logic [SW-1:0]        HALF = (SR > 0) ? (SW'(1) << HS) : '0;
    localparam logic signed [SW-1:0] HMAX = SW'(8388607);
    localparam logic signed [SW-1:0] HMIN = -SW'(8388608);

    // products of the x blend
    logic signed [PW-1:0]  p00_reg, p10_reg, p01_reg, p11_reg;
    logic [FB-1:0]         fz_p_reg;
    logic                  unset_p_reg;
    // x blend sums
    logic signed [AW-1:0]  a_reg, b_reg;
    logic [FB-1:0]         fz_s_reg;
    logic                  unset_s_reg;
    // products of the z blend, integer and fraction parts apart
    logic signed [QHW-1:0] qa_reg, qb_reg;
    logic [LW-1:0]         la_reg, lb_reg;
    logic                  unset_q_reg;
    logic signed [HW-1:0]  hi_reg;
    logic [LSW-1:0]        lo_reg;
    logic                  unset_h_reg;
    logic [OW-1:0]         height_reg;

    logic signed [SB-1:0]  h00, h10, h01, h11;
    logic [WW-1:0]         wx0, wx1, wz0, wz1;
    logic signed [AHW-1:0] ah, bh;
    logic [FB-1:0]         al, bl;
    logic signed [SW-1:0]  s_full;
    logic signed [SW-1:0]  r_full;
    logic [OW-1:0]         height_next;

    always_comb
    begin
        h00 = oor[0] ? '0 : rd00;
        h10 = oor[1] ? '0 : rd10;
        h01 = oor[2] ? '0 : rd01;
        h11 = oor[3] ? '0 : rd11;
        wx1 = {1'b0, fx};
        wx0 = ONE - wx1;
        wz1 = {1'b0, fz_s_reg};
        wz0 = ONE - wz1;
        ah  = a_reg[AW-1:FB];
        bh  = b_reg[AW-1:FB];
        al  = a_reg[FB-1:0];
        bl  = b_reg[FB-1:0];
        s_full = (SW'(hi_reg) <<< FB) + SW'(lo_reg) + HALF;
        r_full = s_full >>> SR;
        if (unset_h_reg)
        begin
            height_next = '0;
        end
        else if (r_full > HMAX)
        begin
            height_next = HMAX[OW-1:0];
        end
        else if (r_full < HMIN)
        begin
            height_next = HMIN[OW-1:0];
        end
        else
        begin
            height_next = r_full[OW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p00_reg     <= PW'(h00) * PW'($signed({1'b0, wx0}));
            p10_reg     <= PW'(h10) * PW'($signed({1'b0, wx1}));
            p01_reg     <= PW'(h01) * PW'($signed({1'b0, wx0}));
            p11_reg     <= PW'(h11) * PW'($signed({1'b0, wx1}));
            fz_p_reg    <= fz;
            unset_p_reg <= unset;
        end
        if (en[1])
        begin
            a_reg       <= AW'(p00_reg) + AW'(p10_reg);
            b_reg       <= AW'(p01_reg) + AW'(p11_reg);
            fz_s_reg    <= fz_p_reg;
            unset_s_reg <= unset_p_reg;
        end
        if (en[2])
        begin
            qa_reg      <= QHW'(ah) * QHW'($signed({1'b0, wz0}));
            qb_reg      <= QHW'(bh) * QHW'($signed({1'b0, wz1}));
            la_reg      <= LW'(al) * LW'(wz0);
            lb_reg      <= LW'(bl) * LW'(wz1);
            unset_q_reg <= unset_s_reg;
        end
        if (en[3])
        begin
            hi_reg      <= HW'(qa_reg) + HW'(qb_reg);
            lo_reg      <= LSW'(la_reg) + LSW'(lb_reg);
            unset_h_reg <= unset_q_reg;
        end
        if (en[4])
        begin
            height_reg  <= height_next;
        end
    end

    assign height = height_reg;

endmodule

// ===== hdl/heightfield_bilinear_sampler.sv =====
// ----------------------------------------------------------------------------
// heightfield_bilinear_sampler
// Height grid with bilinear height queries at world positions.
// ----------------------------------------------------------------------------
// usage:
//   s_* channel takes one beat per item; s_tuser is the opcode (0 = write a
//   sample at sample_address, 1 = query the height at world_x, world_z).
//   m_* channel gives one beat per query: m_tdata is the height with 8
//   fraction bits, m_tuser is set when a grid count or face size is zero.
//   cfg_we / cfg_index / cfg_data load grid width, grid depth and spacing;
//   write them only while no query is in flight.
// timing:
//   one item per cycle sustained while the output is not stalled; the
//   divider stages take 4 quotient bits each. writes update the
//   store when they reach the read stage, so item order is kept.
// reset:
//   clears the config registers and valid bits; sample store content is
//   unknown until written. when m_tready is low the pipeline closes its
//   bubbles and then holds, and s_tready drops once every stage is full.
// ----------------------------------------------------------------------------
module heightfield_bilinear_sampler #(
    parameter int STORE_DEPTH   = hbs_pkg::STORE_DEPTH_DEF,
    parameter int SAMPLE_BITS   = hbs_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = hbs_pkg::FRACTION_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // sample_address[15:0], sample_value[31:16], world_x[63:32], world_z[95:64]
    input  logic [95:0]                       s_tdata,
    // opcode[0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // height[23:0]
    output logic [23:0]                       m_tdata,
    // grid_unset[0]
    output logic                              m_tuser,
    input  logic                              cfg_we,
    input  logic [hbs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [hbs_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    localparam int D        = hbs_pkg::div_stages(FRACTION_BITS);
    localparam int QP       = D * hbs_pkg::DIV_STEP;
    localparam int CB       = hbs_pkg::COUNT_BITS;
    localparam int QW       = CB + FRACTION_BITS;
    localparam int AW       = $clog2(STORE_DEPTH);
    localparam int IW       = hbs_pkg::INDEX_BITS;
    localparam int PB       = hbs_pkg::POS_BITS;
    localparam int FB       = FRACTION_BITS;
    localparam int S_CLAMP  = D + 1;
    localparam int S_INDEX  = D + 2;
    localparam int S_MUL    = D + 3;
    localparam int S_ADDR   = D + 4;
    localparam int S_READ   = D + 5;
    localparam int S_PROD   = D + 6;
    localparam int S_HILO   = D + 9;
    localparam int S_OUT    = D + 10;
    localparam int NS       = D + 11;

    localparam logic [IW-1:0] DEPTH_IDX = IW'(STORE_DEPTH);

    logic [CB-1:0]                  grid_width_reg;
    logic [CB-1:0]                  grid_depth_reg;
    logic [hbs_pkg::FACE_BITS-1:0]  spacing_reg;

    logic [NS-1:0]                  v_reg;
    logic [NS-1:0]                  en;
    hbs_pkg::side_t                 side_reg [S_HILO+1];
    hbs_pkg::side_t                 side_in;

    logic [PB-1:0]                  pos_x_reg, pos_z_reg;
    logic [QP-1:0]                  qx, qz;
    logic                           ovfx, ovfz;
    logic [QW-1:0]                  gx_reg, gz_reg;
    logic [QW-1:0]                  lim_x, lim_z;
    logic [CB-1:0]                  x0_reg, x1_reg, z0_reg, z1_reg;
    logic [CB-1:0]                  x0, z0, x1_next, z1_next;
    logic [FB-1:0]                  fx_i_reg, fz_i_reg, fx_m_reg, fz_m_reg;
    logic [FB-1:0]                  fx_a_reg, fz_a_reg, fx_r_reg, fz_r_reg;
    logic [2*CB-1:0]                rowa_reg, rowb_reg;
    logic [CB-1:0]                  x0_m_reg, x1_m_reg;
    logic [IW-1:0]                  idx00, idx10, idx01, idx11, widx;
    logic [AW-1:0]                  a00_reg, a10_reg, a01_reg, a11_reg;
    logic [3:0]                     oor_a_reg, oor_r_reg;
    logic                           store_we;
    logic [SAMPLE_BITS-1:0]         wdata;
    logic [SAMPLE_BITS-1:0]         rd00, rd10, rd01, rd11;
    logic [hbs_pkg::HEIGHT_BITS-1:0] height;
    logic                           unset_out_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg <= '0;
            grid_depth_reg <= '0;
            spacing_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hbs_pkg::CFG_GRID_WIDTH: grid_width_reg <= cfg_data[CB-1:0];
                hbs_pkg::CFG_GRID_DEPTH: grid_depth_reg <= cfg_data[CB-1:0];
                hbs_pkg::CFG_SPACING:    spacing_reg    <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // a stage moves when it is empty or the one after it moves
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || m_tready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[0];

    always_comb
    begin
        side_in.op    = s_tuser;
        side_in.unset = (grid_width_reg == '0) || (grid_depth_reg == '0) ||
                        (spacing_reg == '0);
        side_in.addr  = s_tdata[15:0];
        side_in.value = s_tdata[31:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    // writes leave the pipeline once they reach the store
                    if (k == S_READ + 1)
                    begin
                        v_reg[k] <= v_reg[k-1] && (side_reg[k-1].op == hbs_pkg::OP_QUERY);
                    end
                    else
                    begin
                        v_reg[k] <= v_reg[k-1];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            side_reg[0] <= side_in;
            pos_x_reg   <= s_tdata[63] ? '0 : s_tdata[62:32];
            pos_z_reg   <= s_tdata[95] ? '0 : s_tdata[94:64];
        end
        for (int k = 1; k <= S_HILO; k++)
        begin
            if (en[k])
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    hbs_divider #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div_x (
        .clk     (clk),
        .en      (en[D:1]),
        .pos     (pos_x_reg),
        .spacing (spacing_reg),
        .quo     (qx),
        .ovf     (ovfx)
    );

    hbs_divider #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div_z (
        .clk     (clk),
        .en      (en[D:1]),
        .pos     (pos_z_reg),
        .spacing (spacing_reg),
        .quo     (qz),
        .ovf     (ovfz)
    );

    always_comb
    begin
        lim_x   = {CB'(grid_width_reg - 1'b1), FB'(0)};
        lim_z   = {CB'(grid_depth_reg - 1'b1), FB'(0)};
        x0      = gx_reg[QW-1:FB];
        z0      = gz_reg[QW-1:FB];
        x1_next = ((CB+1)'(x0) + 1'b1 < (CB+1)'(grid_width_reg)) ?
                  CB'(x0 + 1'b1) : CB'(grid_width_reg - 1'b1);
        z1_next = ((CB+1)'(z0) + 1'b1 < (CB+1)'(grid_depth_reg)) ?
                  CB'(z0 + 1'b1) : CB'(grid_depth_reg - 1'b1);
        idx00   = IW'(rowa_reg) + IW'(x0_m_reg);
        idx10   = IW'(rowa_reg) + IW'(x1_m_reg);
        idx01   = IW'(rowb_reg) + IW'(x0_m_reg);
        idx11   = IW'(rowb_reg) + IW'(x1_m_reg);
        widx    = IW'(side_reg[S_READ-1].addr);
        wdata   = SAMPLE_BITS'($signed(side_reg[S_READ-1].value));
        store_we = en[S_READ] && v_reg[S_READ-1] &&
                   (side_reg[S_READ-1].op == hbs_pkg::OP_WRITE) && (widx < DEPTH_IDX);
    end

    always_ff @(posedge clk)
    begin
        if (en[S_CLAMP])
        begin
            gx_reg <= (ovfx || (qx > QP'(lim_x))) ? lim_x : qx[QW-1:0];
            gz_reg <= (ovfz || (qz > QP'(lim_z))) ? lim_z : qz[QW-1:0];
        end
        if (en[S_INDEX])
        begin
            x0_reg   <= x0;
            z0_reg   <= z0;
            x1_reg   <= x1_next;
            z1_reg   <= z1_next;
            fx_i_reg <= gx_reg[FB-1:0];
            fz_i_reg <= gz_reg[FB-1:0];
        end
        if (en[S_MUL])
        begin
            rowa_reg <= (2*CB)'(z0_reg) * (2*CB)'(grid_width_reg);
            rowb_reg <= (2*CB)'(z1_reg) * (2*CB)'(grid_width_reg);
            x0_m_reg <= x0_reg;
            x1_m_reg <= x1_reg;
            fx_m_reg <= fx_i_reg;
            fz_m_reg <= fz_i_reg;
        end
        if (en[S_ADDR])
        begin
            a00_reg   <= idx00[AW-1:0];
            a10_reg   <= idx10[AW-1:0];
            a01_reg   <= idx01[AW-1:0];
            a11_reg   <= idx11[AW-1:0];
            oor_a_reg <= {idx11 >= DEPTH_IDX, idx01 >= DEPTH_IDX,
                          idx10 >= DEPTH_IDX, idx00 >= DEPTH_IDX};
            fx_a_reg  <= fx_m_reg;
            fz_a_reg  <= fz_m_reg;
        end
        if (en[S_READ])
        begin
            oor_r_reg <= oor_a_reg;
            fx_r_reg  <= fx_a_reg;
            fz_r_reg  <= fz_a_reg;
        end
    end

    // two copies of the store so that four samples come out each cycle the read stage moves
    hbs_store #(
        .DEPTH       (STORE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_store_row0 (
        .clk     (clk),
        .we      (store_we),
        .waddr   (widx[AW-1:0]),
        .wdata   (wdata),
        .re      (en[S_READ]),
        .raddr_a (a00_reg),
        .raddr_b (a10_reg),
        .rdata_a (rd00),
        .rdata_b (rd10)
    );

    hbs_store #(
        .DEPTH       (STORE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_store_row1 (
        .clk     (clk),
        .we      (store_we),
        .waddr   (widx[AW-1:0]),
        .wdata   (wdata),
        .re      (en[S_READ]),
        .raddr_a (a01_reg),
        .raddr_b (a11_reg),
        .rdata_a (rd01),
        .rdata_b (rd11)
    );

    hbs_blend #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_blend (
        .clk    (clk),
        .en     (en[S_OUT:S_PROD]),
        .rd00   (rd00),
        .rd10   (rd10),
        .rd01   (rd01),
        .rd11   (rd11),
        .oor    (oor_r_reg),
        .fx     (fx_r_reg),
        .fz     (fz_r_reg),
        .unset  (side_reg[S_READ].unset),
        .height (height)
    );

    always_ff @(posedge clk)
    begin
        if (en[S_OUT])
        begin
            unset_out_reg <= side_reg[S_HILO].unset;
        end
    end

    assign m_tvalid = v_reg[S_OUT];
    assign m_tdata  = height;
    assign m_tuser  = unset_out_reg;

endmodule

// ===== hdl/hbs_checker.sv =====
// ----------------------------------------------------------------------------
// hbs_checker
// Port-level checks of the height-field sampler, bound to the top level.
// ----------------------------------------------------------------------------
module hbs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);

    // a held result keeps its valid
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // a held result keeps its data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // a free output side never stalls the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input stalled with output free");

    // unset grid reports zero height
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 24'd0)
        else $error("unset grid with nonzero height");

endmodule

bind heightfield_bilinear_sampler hbs_checker u_hbs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
